// ===== hdl/wpd_pkg.sv =====
// ----------------------------------------------------------------------------
// wpd_pkg
// Shared types and constants of the workload phase detector.
// ----------------------------------------------------------------------------
package wpd_pkg;

  localparam int CNT_W    = 40;
  localparam int CNTIN_W  = 16;
  localparam int WIN_W    = 32;
  localparam int Q16_W    = 17;
  localparam int INT_W    = 24;
  localparam int TREND_W  = 18;
  localparam int QUO_W    = 24;
  localparam int ITER_W   = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 64;

  localparam int HISTORY_DEPTH_DEF = 16;

  localparam logic [WIN_W-1:0]  WINDOW_RST   = 32'd100000;
  localparam logic [Q16_W-1:0]  THRESH_RST   = 17'd13107;
  localparam logic [INT_W-1:0]  HI_INT_RST   = 24'd25600;
  localparam logic [Q16_W-1:0]  HI_MISS_RST  = 17'd6554;

  localparam logic [Q16_W-1:0]  ONE_Q16      = 17'd65536;
  localparam logic [INT_W-1:0]  INT_MAX      = 24'hFFFFFF;
  localparam logic [CNT_W-1:0]  CNT_MAX      = 40'hFF_FFFF_FFFF;

  localparam logic [ITER_W-1:0] ITER_Q16     = 5'd16;
  localparam logic [ITER_W-1:0] ITER_INT     = 5'd24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW  = 2'd0,
    REG_THRESH  = 2'd1,
    REG_HI_INT  = 2'd2,
    REG_HI_MISS = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CLS_MEMORY  = 2'd0,
    CLS_COMPUTE = 2'd1,
    CLS_MIXED   = 2'd2
  } phase_class_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RATE, ST_RATE_W, ST_INT_PREP, ST_INT, ST_INT_W, ST_SIM, ST_SIM_W,
    ST_CMP, ST_PUSH, ST_WALK_INIT, ST_WALK, ST_PROD, ST_DIFF, ST_TREND, ST_TREND_W,
    ST_DONE
  } wpd_state_t;

  typedef struct packed {
    logic              start;
    logic [ITER_W-1:0] count;
  } div_req_t;

endpackage

// ===== hdl/wpd_divider.sv =====
// ----------------------------------------------------------------------------
// wpd_divider
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wpd_divider (
  input  logic                        clk,
  input  logic                        rst_n,
  input  wpd_pkg::div_req_t           req,
  input  logic [wpd_pkg::CNT_W-1:0]   rem_init,
  input  logic [wpd_pkg::QUO_W-1:0]   low,
  input  logic [wpd_pkg::CNT_W-1:0]   divisor,
  output logic                        done,
  output logic [wpd_pkg::QUO_W-1:0]   quo
);

  logic [wpd_pkg::CNT_W-1:0]  rem_r;
  logic [wpd_pkg::QUO_W-1:0]  low_r;
  logic [wpd_pkg::CNT_W-1:0]  div_r;
  logic [wpd_pkg::QUO_W-1:0]  quo_r;
  logic [wpd_pkg::ITER_W-1:0] cnt_r;
  logic                       done_r;
  logic [wpd_pkg::CNT_W:0]    trial;
  logic [wpd_pkg::CNT_W:0]    diff;
  logic                       ge;

  // The remainder always stays below the divisor, so the shifted value fits
  // one extra bit.
  assign trial = {rem_r, low_r[wpd_pkg::QUO_W-1]};
  assign ge    = trial >= {1'b0, div_r};
  assign diff  = trial - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        cnt_r <= req.count;
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == wpd_pkg::ITER_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= rem_init;
      low_r <= low;
      div_r <= divisor;
      quo_r <= '0;
    end else if (cnt_r != '0) begin
      rem_r <= ge ? diff[wpd_pkg::CNT_W-1:0] : trial[wpd_pkg::CNT_W-1:0];
      low_r <= {low_r[wpd_pkg::QUO_W-2:0], 1'b0};
      quo_r <= {quo_r[wpd_pkg::QUO_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== hdl/wpd_history.sv =====
// ----------------------------------------------------------------------------
// wpd_history
// Miss-rate history memory with one write port and a registered read port.
// ----------------------------------------------------------------------------
module wpd_history #(
  parameter int HISTORY_DEPTH = wpd_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(HISTORY_DEPTH)-1:0] waddr,
  input  logic [wpd_pkg::Q16_W-1:0]        wdata,
  input  logic [$clog2(HISTORY_DEPTH)-1:0] raddr,
  output logic [wpd_pkg::Q16_W-1:0]        rdata
);

  logic [wpd_pkg::Q16_W-1:0] mem [HISTORY_DEPTH];
  logic [wpd_pkg::Q16_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/workload_phase_detector_unit.sv =====
// ----------------------------------------------------------------------------
// workload_phase_detector_unit
// Window counters, phase classification, change detection and miss-rate
// trend over a bounded history, sequenced around one shared divider.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake            Payload
//  in_      input      in_tvalid/in_tready  tdata: instr, accesses, misses; tuser: kind
//  out_     output     out_tvalid/out_tready tdata: result fields
//  cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// An item that does not close a window is answered from the idle state. A
// closing item runs the divider up to four times (miss rate, intensity,
// similarity and trend) plus a walk over the history memory. in_tready is
// low while a close is in progress or the output register holds a result
// that is not taken. Reset is synchronous.
module workload_phase_detector_unit #(
  parameter int HISTORY_DEPTH = wpd_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [15:0] instructions, [31:16] accesses, [47:32] misses
  input  logic [wpd_pkg::IN_DATA_W-1:0]    in_tdata,
  // [0] kind
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] window_closed, [1] phase change flag, [3:2] phase_class,
  // [20:4] window_miss_rate, [44:21] window_intensity, [62:45] miss_trend
  output logic [wpd_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [wpd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wpd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int HW   = $clog2(HISTORY_DEPTH);
  localparam int FW   = $clog2(HISTORY_DEPTH + 1);
  localparam int SYW  = wpd_pkg::Q16_W + FW;
  localparam int SXW  = 2 * FW;
  localparam int SXYW = wpd_pkg::Q16_W + 2 * FW;
  localparam int SXXW = 3 * FW;
  localparam int PW   = wpd_pkg::Q16_W + 3 * FW;
  localparam int DW   = 4 * FW;
  localparam int NW   = PW + 1;
  localparam int CW   = 64;
  localparam logic [HW-1:0] LAST_IDX = HW'(HISTORY_DEPTH - 1);
  localparam logic [FW-1:0] DEPTH_F  = FW'(HISTORY_DEPTH);

  localparam int CN = wpd_pkg::CNT_W;

  // configuration
  logic [wpd_pkg::WIN_W-1:0] win_r;
  logic [wpd_pkg::Q16_W-1:0] thr_r;
  logic [wpd_pkg::INT_W-1:0] hi_int_r;
  logic [wpd_pkg::Q16_W-1:0] hi_miss_r;

  wpd_pkg::wpd_state_t state_r, state_nxt;

  logic [CN-1:0] tot_i_r, tot_a_r, tot_m_r;
  logic [CN-1:0] sum_i, sum_a, sum_m;
  logic          accept, close_go;

  logic [wpd_pkg::Q16_W-1:0] rate_r, term_r, tmag_r;
  logic [wpd_pkg::INT_W-1:0] int_r, last_int_r;
  logic                      last_acc_r, chg_r, tneg_r;
  wpd_pkg::phase_class_t     cls_r;
  logic [46:0]               a125_r;
  logic [FW-1:0]             fill_r, iss_r;
  logic [HW-1:0]             head_r, ptr_r, prev_idx, start_idx, raddr;
  logic                      v_r;
  logic [FW-1:0]             x_r;
  logic [SYW-1:0]            sy_r;
  logic [SXW-1:0]            sx_r;
  logic [SXYW-1:0]           sxy_r;
  logic [SXXW-1:0]           sxx_r;
  logic [PW-1:0]             p1_r, p2_r;
  logic [DW-1:0]             p3_r, p4_r, den_r;
  logic signed [NW-1:0]      num_r;
  logic                      den_pos_r;

  logic                      out_valid_r;
  logic [wpd_pkg::OUT_DATA_W-1:0] out_data_r;
  logic                      out_free;

  // shared divider
  wpd_pkg::div_req_t         div_req;
  logic [CN-1:0]             div_rem, div_dsr;
  logic [wpd_pkg::QUO_W-1:0] div_low, div_quo;
  logic                      div_done;

  logic [wpd_pkg::Q16_W-1:0] hist_q;
  logic                      hist_we;

  // condition terms
  logic                      has_acc, miss_ge;
  logic [57:0]               int_num;
  logic                      int_ovf;
  logic [wpd_pkg::INT_W-1:0] idiff, imax;
  logic [wpd_pkg::Q16_W-1:0] rdiff;
  logic                      sim_skip, sim_acc_mis, sim_div;
  logic [PW-1:0]             mag;
  logic                      tr_sat;
  logic [wpd_pkg::Q16_W:0]   sim_dist;
  wpd_pkg::phase_class_t     cls_nxt;
  logic [wpd_pkg::TREND_W-1:0] trend;

  function automatic logic [CN-1:0] sat_add(input logic [CN-1:0] a,
                                            input logic [wpd_pkg::CNTIN_W-1:0] b);
    logic [CN:0] s;
    s = {1'b0, a} + (CN+1)'(b);
    return s[CN] ? wpd_pkg::CNT_MAX : s[CN-1:0];
  endfunction

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == wpd_pkg::ST_IDLE) && out_free;
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign sum_i    = sat_add(tot_i_r, in_tdata[15:0]);
  assign sum_a    = sat_add(tot_a_r, in_tdata[31:16]);
  assign sum_m    = sat_add(tot_m_r, in_tdata[47:32]);
  assign close_go = in_tuser && (sum_i >= CN'(win_r));

  assign has_acc  = tot_a_r != '0;
  assign miss_ge  = tot_m_r >= tot_a_r;
  assign int_num  = {a125_r, 11'b0};
  assign int_ovf  = CW'(int_num) >= {tot_i_r, 24'b0};

  assign prev_idx  = (head_r == '0) ? LAST_IDX : head_r - 1'b1;
  assign start_idx = (head_r >= HW'(fill_r)) ? head_r - HW'(fill_r)
                                              : HW'(head_r + HW'(DEPTH_F) - HW'(fill_r));
  assign raddr     = (state_r == wpd_pkg::ST_WALK) ? ptr_r : prev_idx;

  assign idiff = (int_r > last_int_r) ? int_r - last_int_r : last_int_r - int_r;
  assign imax  = (int_r > last_int_r) ? int_r : last_int_r;
  assign rdiff = (hist_q > rate_r) ? hist_q - rate_r : rate_r - hist_q;
  assign sim_skip    = fill_r == '0;
  assign sim_acc_mis = !has_acc || !last_acc_r;
  assign sim_div     = !sim_skip && !sim_acc_mis && (imax != '0) && (idiff != imax);
  assign sim_dist    = {1'b0, rdiff} + {1'b0, term_r};

  assign mag    = num_r[NW-1] ? PW'(-num_r) : PW'(num_r);
  assign tr_sat = CW'(mag) >= CW'({den_r, 16'b0});

  always_comb begin
    if (!has_acc) begin
      cls_nxt = wpd_pkg::CLS_COMPUTE;
    end else if (int_r > hi_int_r && rate_r > hi_miss_r) begin
      cls_nxt = wpd_pkg::CLS_MEMORY;
    end else if ({int_r, 1'b0} < {1'b0, hi_int_r}) begin
      cls_nxt = wpd_pkg::CLS_COMPUTE;
    end else begin
      cls_nxt = wpd_pkg::CLS_MIXED;
    end
  end

  assign trend = tneg_r ? -{1'b0, tmag_r} : {1'b0, tmag_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wpd_pkg::ST_IDLE:      if (accept && close_go) state_nxt = wpd_pkg::ST_RATE;
      wpd_pkg::ST_RATE: begin
        if (!has_acc) state_nxt = wpd_pkg::ST_SIM;
        else if (miss_ge) state_nxt = wpd_pkg::ST_INT_PREP;
        else state_nxt = wpd_pkg::ST_RATE_W;
      end
      wpd_pkg::ST_RATE_W:    if (div_done) state_nxt = wpd_pkg::ST_INT_PREP;
      wpd_pkg::ST_INT_PREP:  state_nxt = wpd_pkg::ST_INT;
      wpd_pkg::ST_INT:       state_nxt = int_ovf ? wpd_pkg::ST_SIM : wpd_pkg::ST_INT_W;
      wpd_pkg::ST_INT_W:     if (div_done) state_nxt = wpd_pkg::ST_SIM;
      wpd_pkg::ST_SIM: begin
        if (sim_skip || sim_acc_mis) state_nxt = wpd_pkg::ST_PUSH;
        else if (sim_div) state_nxt = wpd_pkg::ST_SIM_W;
        else state_nxt = wpd_pkg::ST_CMP;
      end
      wpd_pkg::ST_SIM_W:     if (div_done) state_nxt = wpd_pkg::ST_CMP;
      wpd_pkg::ST_CMP:       state_nxt = wpd_pkg::ST_PUSH;
      wpd_pkg::ST_PUSH:      state_nxt = wpd_pkg::ST_WALK_INIT;
      wpd_pkg::ST_WALK_INIT: begin
        state_nxt = (fill_r < FW'(2)) ? wpd_pkg::ST_DONE : wpd_pkg::ST_WALK;
      end
      wpd_pkg::ST_WALK:      if (iss_r == fill_r && !v_r) state_nxt = wpd_pkg::ST_PROD;
      wpd_pkg::ST_PROD:      state_nxt = wpd_pkg::ST_DIFF;
      wpd_pkg::ST_DIFF:      state_nxt = wpd_pkg::ST_TREND;
      wpd_pkg::ST_TREND: begin
        state_nxt = (den_pos_r && !tr_sat) ? wpd_pkg::ST_TREND_W : wpd_pkg::ST_DONE;
      end
      wpd_pkg::ST_TREND_W:   if (div_done) state_nxt = wpd_pkg::ST_DONE;
      wpd_pkg::ST_DONE:      if (out_free) state_nxt = wpd_pkg::ST_IDLE;
      default:               state_nxt = wpd_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs: divider requests and operands, history write
  always_comb begin
    div_req.start = 1'b0;
    div_req.count = wpd_pkg::ITER_Q16;
    div_rem       = tot_m_r;
    div_low       = '0;
    div_dsr       = tot_a_r;
    hist_we       = 1'b0;
    case (state_r)
      wpd_pkg::ST_RATE: begin
        div_req.start = has_acc && !miss_ge;
      end
      wpd_pkg::ST_INT: begin
        div_req.start = !int_ovf;
        div_req.count = wpd_pkg::ITER_INT;
        div_rem       = CN'(int_num[57:24]);
        div_low       = int_num[23:0];
        div_dsr       = tot_i_r;
      end
      wpd_pkg::ST_SIM: begin
        div_req.start = sim_div;
        div_rem       = CN'(idiff);
        div_dsr       = CN'(imax);
      end
      wpd_pkg::ST_TREND: begin
        div_req.start = den_pos_r && !tr_sat;
        div_rem       = CN'(mag >> 16);
        div_low       = {mag[15:0], 8'b0};
        div_dsr       = CN'(den_r);
      end
      wpd_pkg::ST_PUSH: begin
        hist_we = 1'b1;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  wpd_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .rem_init (div_rem),
    .low      (div_low),
    .divisor  (div_dsr),
    .done     (div_done),
    .quo      (div_quo)
  );

  wpd_history #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_hist (
    .clk   (clk),
    .we    (hist_we),
    .waddr (head_r),
    .wdata (rate_r),
    .raddr (raddr),
    .rdata (hist_q)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wpd_pkg::ST_IDLE;
      win_r       <= wpd_pkg::WINDOW_RST;
      thr_r       <= wpd_pkg::THRESH_RST;
      hi_int_r    <= wpd_pkg::HI_INT_RST;
      hi_miss_r   <= wpd_pkg::HI_MISS_RST;
      tot_i_r     <= '0;
      tot_a_r     <= '0;
      tot_m_r     <= '0;
      fill_r      <= '0;
      head_r      <= '0;
      last_int_r  <= '0;
      last_acc_r  <= 1'b0;
      out_valid_r <= 1'b0;
      v_r         <= 1'b0;
      iss_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        case (wpd_pkg::cfg_reg_t'(cfg_index))
          wpd_pkg::REG_WINDOW:  win_r     <= cfg_data;
          wpd_pkg::REG_THRESH:  thr_r     <= cfg_data[wpd_pkg::Q16_W-1:0];
          wpd_pkg::REG_HI_INT:  hi_int_r  <= cfg_data[wpd_pkg::INT_W-1:0];
          wpd_pkg::REG_HI_MISS: hi_miss_r <= cfg_data[wpd_pkg::Q16_W-1:0];
          default:              win_r     <= win_r;
        endcase
      end
      // A new result loads the output register even while the old one is
      // being taken in the same cycle.
      if ((accept && !close_go) || (state_r == wpd_pkg::ST_DONE && out_free)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (accept) begin
        tot_i_r <= sum_i;
        tot_a_r <= sum_a;
        tot_m_r <= sum_m;
      end
      if (state_r == wpd_pkg::ST_PUSH) begin
        head_r     <= (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
        fill_r     <= (fill_r == DEPTH_F) ? fill_r : fill_r + 1'b1;
        last_int_r <= int_r;
        last_acc_r <= has_acc;
      end
      if (state_r == wpd_pkg::ST_WALK_INIT) begin
        iss_r <= '0;
        v_r   <= 1'b0;
      end
      if (state_r == wpd_pkg::ST_WALK) begin
        v_r <= iss_r < fill_r;
        if (iss_r < fill_r) begin
          iss_r <= iss_r + 1'b1;
        end
      end
      if (state_r == wpd_pkg::ST_DONE && out_free) begin
        tot_i_r     <= '0;
        tot_a_r     <= '0;
        tot_m_r     <= '0;
      end
    end
  end

  // datapath payload
  always_ff @(posedge clk) begin
    if (accept && !close_go) begin
      out_data_r <= '0;
    end
    case (state_r)
      wpd_pkg::ST_RATE: begin
        rate_r <= (has_acc && miss_ge) ? wpd_pkg::ONE_Q16 : '0;
        int_r  <= '0;
        a125_r <= 47'({tot_a_r, 7'b0}) - 47'({tot_a_r, 2'b0}) + 47'(tot_a_r);
        chg_r  <= 1'b0;
        term_r <= '0;
      end
      wpd_pkg::ST_RATE_W: if (div_done) rate_r <= {1'b0, div_quo[15:0]};
      wpd_pkg::ST_INT:    if (int_ovf) int_r <= wpd_pkg::INT_MAX;
      wpd_pkg::ST_INT_W:  if (div_done) int_r <= div_quo;
      wpd_pkg::ST_SIM: begin
        cls_r <= cls_nxt;
        if (!sim_skip && sim_acc_mis) begin
          chg_r <= thr_r < wpd_pkg::ONE_Q16;
        end
        // equal distance and maximum give exactly one
        term_r <= (imax != '0 && idiff == imax) ? wpd_pkg::ONE_Q16 : '0;
      end
      wpd_pkg::ST_SIM_W:  if (div_done) term_r <= {1'b0, div_quo[15:0]};
      wpd_pkg::ST_CMP:    chg_r <= sim_dist > {thr_r, 1'b0};
      wpd_pkg::ST_WALK_INIT: begin
        ptr_r  <= start_idx;
        sy_r   <= '0;
        sx_r   <= '0;
        sxy_r  <= '0;
        sxx_r  <= '0;
        tmag_r <= '0;
        tneg_r <= 1'b0;
      end
      wpd_pkg::ST_WALK: begin
        if (iss_r < fill_r) begin
          ptr_r <= (ptr_r == LAST_IDX) ? '0 : ptr_r + 1'b1;
          x_r   <= iss_r;
        end
        if (v_r) begin
          sy_r  <= sy_r + SYW'(hist_q);
          sx_r  <= sx_r + SXW'(x_r);
          sxy_r <= sxy_r + SXYW'(x_r) * SXYW'(hist_q);
          sxx_r <= sxx_r + SXXW'(x_r) * SXXW'(x_r);
        end
      end
      wpd_pkg::ST_PROD: begin
        p1_r <= PW'(fill_r) * PW'(sxy_r);
        p2_r <= PW'(sx_r) * PW'(sy_r);
        p3_r <= DW'(fill_r) * DW'(sxx_r);
        p4_r <= DW'(sx_r) * DW'(sx_r);
      end
      wpd_pkg::ST_DIFF: begin
        num_r     <= $signed({1'b0, p1_r}) - $signed({1'b0, p2_r});
        den_r     <= p3_r - p4_r;
        den_pos_r <= p3_r > p4_r;
      end
      wpd_pkg::ST_TREND: begin
        tneg_r <= num_r[NW-1];
        tmag_r <= (den_pos_r && tr_sat) ? wpd_pkg::ONE_Q16 : '0;
      end
      wpd_pkg::ST_TREND_W: if (div_done) tmag_r <= {1'b0, div_quo[15:0]};
      wpd_pkg::ST_DONE: begin
        if (out_free) begin
          out_data_r <= {1'b0, trend, int_r, rate_r, cls_r, chg_r, 1'b1};
        end
      end
      default: begin
        x_r <= x_r;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== sim/workload_phase_detector_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// workload_phase_detector_unit_test
// Self-checking bench for the phase detector. Counter items are streamed in
// with random gaps and output stalls. A scoreboard class predicts every
// result from its own copy of the counters, history and registers. Several
// register settings are applied while the block is idle.
// ----------------------------------------------------------------------------
module workload_phase_detector_unit_test;

  class phase_scoreboard;
    bit [wpd_pkg::WIN_W-1:0]   win_len;
    bit [wpd_pkg::Q16_W-1:0]   chg_thr;
    bit [wpd_pkg::INT_W-1:0]   hi_int;
    bit [wpd_pkg::Q16_W-1:0]   hi_miss;
    bit [wpd_pkg::CNT_W-1:0]   instr_sum, acc_sum, miss_sum;
    bit [wpd_pkg::Q16_W-1:0]   rate_hist[wpd_pkg::HISTORY_DEPTH_DEF];
    int                        fill, head;
    bit [wpd_pkg::INT_W-1:0]   prev_int;
    bit                        prev_had_acc;
    bit [wpd_pkg::OUT_DATA_W-1:0] pending[$];
    int                        errors;

    function new();
      win_len = wpd_pkg::WINDOW_RST;
      chg_thr = wpd_pkg::THRESH_RST;
      hi_int  = wpd_pkg::HI_INT_RST;
      hi_miss = wpd_pkg::HI_MISS_RST;
    endfunction

    function void set_reg(wpd_pkg::cfg_reg_t r, bit [wpd_pkg::CFG_DATA_W-1:0] v);
      case (r)
        wpd_pkg::REG_WINDOW:  win_len = v;
        wpd_pkg::REG_THRESH:  chg_thr = v[wpd_pkg::Q16_W-1:0];
        wpd_pkg::REG_HI_INT:  hi_int  = v[wpd_pkg::INT_W-1:0];
        wpd_pkg::REG_HI_MISS: hi_miss = v[wpd_pkg::Q16_W-1:0];
        default: ;
      endcase
    endfunction

    function bit [wpd_pkg::CNT_W-1:0] sat_add(bit [wpd_pkg::CNT_W-1:0] a,
                                              bit [wpd_pkg::CNTIN_W-1:0] b);
      bit [wpd_pkg::CNT_W:0] s;
      s = {1'b0, a} + (wpd_pkg::CNT_W+1)'(b);
      return (s > wpd_pkg::CNT_MAX) ? wpd_pkg::CNT_MAX : s[wpd_pkg::CNT_W-1:0];
    endfunction

    function longint slope_of_history();
      longint n, sx, sy, sxy, sxx, num, den, slope, y;
      int start;
      if (fill < 2) return 0;
      n = fill; sx = 0; sy = 0; sxy = 0; sxx = 0;
      start = (head + wpd_pkg::HISTORY_DEPTH_DEF - fill) % wpd_pkg::HISTORY_DEPTH_DEF;
      for (int i = 0; i < fill; i++) begin
        y = rate_hist[(start + i) % wpd_pkg::HISTORY_DEPTH_DEF];
        sx += i; sy += y; sxy += i * y; sxx += i * i;
      end
      num = n * sxy - sx * sy;
      den = n * sxx - sx * sx;
      if (den <= 0) return 0;
      slope = num / den;
      if (slope > 65536) slope = 65536;
      if (slope < -65536) slope = -65536;
      return slope;
    endfunction

    // Called for every accepted request; queues the result it must produce.
    function void note(bit kind, bit [15:0] ins, bit [15:0] acc, bit [15:0] mis);
      longint unsigned rate, intens, d, mx, ad;
      bit has_acc, changed;
      wpd_pkg::phase_class_t cls;
      longint trend;
      bit [wpd_pkg::TREND_W-1:0] tr;
      instr_sum = sat_add(instr_sum, ins);
      acc_sum   = sat_add(acc_sum, acc);
      miss_sum  = sat_add(miss_sum, mis);
      if (!kind || instr_sum < win_len) begin
        pending.insert(pending.size(), '0);
        return;
      end
      rate = 0; intens = 0; changed = 0;
      has_acc = acc_sum != 0;
      if (has_acc) begin
        rate = (longint'(miss_sum) * 65536) / acc_sum;
        if (miss_sum >= acc_sum) rate = 65536;
        if (instr_sum == 0) intens = 64'(wpd_pkg::INT_MAX);
        else begin
          intens = (longint'(acc_sum) * 256000) / instr_sum;
          if (intens > wpd_pkg::INT_MAX) intens = 64'(wpd_pkg::INT_MAX);
        end
      end
      if (!has_acc) cls = wpd_pkg::CLS_COMPUTE;
      else if (intens > hi_int && rate > hi_miss) cls = wpd_pkg::CLS_MEMORY;
      else if (2 * intens < hi_int) cls = wpd_pkg::CLS_COMPUTE;
      else cls = wpd_pkg::CLS_MIXED;
      if (fill > 0) begin
        if (!has_acc || !prev_had_acc) changed = chg_thr < 65536;
        else begin
          ad = 64'(rate_hist[(head + wpd_pkg::HISTORY_DEPTH_DEF - 1) %
                             wpd_pkg::HISTORY_DEPTH_DEF]);
          d  = (ad > rate) ? ad - rate : rate - ad;
          mx = (intens > prev_int) ? intens : 64'(prev_int);
          if (mx != 0)
            d += (((intens > prev_int) ? intens - prev_int : prev_int - intens)
                  * 65536) / mx;
          changed = d > 2 * longint'(chg_thr);
        end
      end
      rate_hist[head] = rate[wpd_pkg::Q16_W-1:0];
      head = (head + 1) % wpd_pkg::HISTORY_DEPTH_DEF;
      if (fill < wpd_pkg::HISTORY_DEPTH_DEF) fill++;
      prev_int = intens[wpd_pkg::INT_W-1:0];
      prev_had_acc = has_acc;
      trend = slope_of_history();
      tr = trend[wpd_pkg::TREND_W-1:0];
      instr_sum = 0; acc_sum = 0; miss_sum = 0;
      pending.insert(pending.size(), {1'b0, tr, intens[wpd_pkg::INT_W-1:0],
                                      rate[wpd_pkg::Q16_W-1:0], cls, changed, 1'b1});
    endfunction

    function void check(logic [wpd_pkg::OUT_DATA_W-1:0] got);
      bit [wpd_pkg::OUT_DATA_W-1:0] exp;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result with nothing expected: %h", got);
        return;
      end
      exp = pending[0];
      pending.delete(0);
      if (got[0] !== exp[0] || got[1] !== exp[1] || got[3:2] !== exp[3:2] ||
          got[20:4] !== exp[20:4] || got[44:21] !== exp[44:21] ||
          got[62:45] !== exp[62:45]) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch (exp/got): closed %0d/%0d changed %0d/%0d class %0d/%0d",
                   exp[0], got[0], exp[1], got[1], exp[3:2], got[3:2]);
          $display("  rate %0d/%0d int %0d/%0d trend %0d/%0d",
                   exp[20:4], got[20:4], exp[44:21], got[44:21],
                   $signed(exp[62:45]), $signed(got[62:45]));
        end
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_tvalid, in_tready, in_tuser;
  logic [wpd_pkg::IN_DATA_W-1:0] in_tdata;
  logic out_tvalid, out_tready;
  logic [wpd_pkg::OUT_DATA_W-1:0] out_tdata;
  logic cfg_valid, cfg_ready;
  logic [wpd_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [wpd_pkg::CFG_DATA_W-1:0] cfg_data;

  phase_scoreboard sb = new();
  bit   steady;
  int   hold_left, rx_gap, idle_cycles;

  workload_phase_detector_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Handshake signals are stable at the falling edge, so a result seen there
  // is the one taken at the next rising edge.
  always @(negedge clk) begin
    if (out_tvalid && out_tready) sb.check(out_tdata);
  end

  // Result side: random stalls, plus a long hold-off when requested.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (rx_gap > 0) begin
      out_tready <= 1'b0;
      rx_gap <= rx_gap - 1;
    end else begin
      out_tready <= 1'b1;
      if (!steady) begin
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) rx_gap <= $urandom_range(1, 3);
        else if (r < 17) rx_gap <= $urandom_range(20, 60);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_counts(bit kind, bit [15:0] ins, bit [15:0] acc, bit [15:0] mis);
    int g;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {mis, acc, ins};
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    sb.note(kind, ins, acc, mis);
    if (!steady) begin
      g = $urandom_range(0, 99);
      if (g < 20) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else if (g < 22) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(20, 80)) @(posedge clk);
      end
    end
  endtask

  // Lets every expected result arrive, then keeps the input idle before returning.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_reg(wpd_pkg::cfg_reg_t r, bit [wpd_pkg::CFG_DATA_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(r, v);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(bit [31:0] w, bit [31:0] t, bit [31:0] hi, bit [31:0] hm);
    write_reg(wpd_pkg::REG_WINDOW, w);
    write_reg(wpd_pkg::REG_THRESH, t);
    write_reg(wpd_pkg::REG_HI_INT, hi);
    write_reg(wpd_pkg::REG_HI_MISS, hm);
  endtask

  task automatic random_counts(int n, int close_pct);
    bit [15:0] ins, acc, mis;
    int m;
    repeat (n) begin
      m = $urandom_range(0, 99);
      ins = (m < 5) ? 16'hFFFF : (m < 10) ? 16'h0 : 16'($urandom_range(0, 65535));
      m = $urandom_range(0, 99);
      if (m < 40) acc = 16'($urandom_range(0, 65535));
      else if (m < 90) acc = 16'($urandom_range(0, ins / 4));
      else acc = 0;
      m = $urandom_range(0, 99);
      mis = (m < 80) ? 16'($urandom_range(0, acc)) : 16'($urandom_range(0, 65535));
      send_counts($urandom_range(0, 99) < close_pct, ins, acc, mis);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid <= 1'b0; in_tuser <= 1'b0; in_tdata <= '0;
    cfg_valid <= 1'b0; cfg_index <= wpd_pkg::REG_WINDOW; cfg_data <= '0;
    out_tready <= 1'b0;
    steady = 1'b1; hold_left = 0; rx_gap = 0; idle_cycles = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default registers: saturated miss rate, first window, window without
    // accesses after one with them.
    send_counts(0, 16'h0, 16'h0, 16'h0);
    send_counts(0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_counts(1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_counts(1, 16'hFFFF, 16'h0, 16'h0);
    send_counts(1, 16'hFFFF, 16'h0, 16'h0);
    send_counts(0, 16'hFFFF, 16'd100, 16'd5);
    send_counts(1, 16'hFFFF, 16'd100, 16'd5);
    send_counts(1, 16'hFFFF, 16'hFFFF, 16'd20000);
    send_counts(1, 16'hFFFF, 16'd4000, 16'd100);
    send_counts(1, 16'hFFFF, 16'd4000, 16'd100);
    drain();
    // A zero window length lets empty and instruction-free windows close.
    write_reg(wpd_pkg::REG_WINDOW, 32'd0);
    send_counts(1, 16'h0, 16'h0, 16'h0);
    send_counts(1, 16'h0, 16'd5, 16'd1);
    send_counts(1, 16'h0, 16'hFFFF, 16'h0);
    send_counts(1, 16'd1000, 16'd50, 16'd50);
    drain();

    steady = 1'b0;
    apply_setting(32'd20000, 32'd13107, 32'd25600, 32'd6554);
    fork
      random_counts(300, 35);
      begin
        repeat (200) @(posedge clk);
        hold_left = 400;
      end
    join
    drain();
    // Sender waits here for every expected result before going on.
    apply_setting(32'd1, 32'd0, 32'd0, 32'd0);
    random_counts(250, 50);
    drain();
    apply_setting(32'd60000, 32'd65536, 32'hFFFFFF, 32'd65536);
    random_counts(250, 40);
    drain();
    apply_setting(32'hFFFFFFFF, 32'd40000, 32'd1000, 32'd100);
    random_counts(60, 50);
    drain();
    steady = 1'b1;
    apply_setting(32'd150000, 32'd32768, 32'd100000, 32'd20000);
    random_counts(200, 40);
    drain();
    steady = 1'b0;
    apply_setting(32'd30000, 32'd6554, 32'd25600, 32'd6554);
    random_counts(480, 35);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/wpd_pkg.sv
hdl/wpd_divider.sv
hdl/wpd_history.sv
hdl/workload_phase_detector_unit.sv
sim/workload_phase_detector_unit_test.sv
